@@ sv/ilirs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the indexed list block
// no dependencies
package ilirs_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 9;
  localparam int KEY_W    = 32;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    OP_INS_AT     = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_REM_AT     = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_POP_BACK   = 3'd5,
    OP_FIND       = 3'd6
  } op_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_code_t;

  typedef struct packed {
    logic [2:0]              operation;
    logic [CNT_W-1:0]        position;
    logic signed [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [CNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctl_sts_t;

endpackage

@@ sv/indexed_list_insert_remove_search.sv @@
`timescale 1ns / 1ps
// Ordered list of up to 256 signed 32-bit keys held in one 256-entry memory.
// Each transfer on in_ carries one operation and yields one transfer on out_
// with a status, a found flag and the new count. One item at a time is worked
// on, because the memory reads and writes one entry per cycle. The work for an
// item grows with n, the number of entries moved (insert: count - position,
// removal: count - 1 - position) or scanned (find: count). n is zero for
// append, pop back, find on an empty list, rejected operations and the unused
// code. The next item can be accepted from the first edge that can take the
// result. A finished result sits in an output register, and an item only waits
// to finish while the previous result is still held there. No clearing pass is
// needed after reset.
// depends on ilirs_pkg, ilirs_ctrl, ilirs_dp
module indexed_list_insert_remove_search import ilirs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ilirs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ilirs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/ilirs_ram.sv @@
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module ilirs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ilirs_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer for the indexed list: accept, decide, scan or shift, finish
// depends on ilirs_pkg
module ilirs_ctrl import ilirs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.start = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/ilirs_dp.sv @@
`timescale 1ns / 1ps
// datapath: item register, entry memory, shift and scan pointers, result register
// depends on ilirs_pkg and ilirs_ram
module ilirs_dp import ilirs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  item_t    in_data,
  input  ctl_cmd_t cmd,
  output ctl_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_data
);

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_INS  = 2'd1,
    ACT_REM  = 2'd2,
    ACT_FIND = 2'd3
  } act_t;

  item_t            item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  act_t             act_r, act_d;
  status_code_t     status_r, status_d;
  logic [CNT_W-1:0] ep_d, rem_d, ptr_d;
  logic [ADDR_W-1:0] ep_r;
  logic [CNT_W-1:0] rem_r, ptr_r;
  logic             pend_r;
  logic [ADDR_W-1:0] wa_r;
  logic             found_r;
  logic             out_valid_r;
  result_t          out_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [KEY_W-1:0]  wdata;
  logic [KEY_W-1:0]  rdata;
  logic              issue;

  // classify the held item against the current count
  always_comb begin
    act_d    = ACT_NONE;
    status_d = ST_OK;
    ep_d     = '0;
    case (item_r.operation)
      OP_INS_AT: begin
        if (item_r.position > count_r) begin
          status_d = ST_RANGE;
        end else if (count_r == CAP_CNT) begin
          status_d = ST_FULL;
        end else begin
          act_d = ACT_INS;
          ep_d  = item_r.position;
        end
      end
      OP_PUSH_FRONT: begin
        if (count_r == CAP_CNT) begin
          status_d = ST_FULL;
        end else begin
          act_d = ACT_INS;
        end
      end
      OP_PUSH_BACK: begin
        if (count_r == CAP_CNT) begin
          status_d = ST_FULL;
        end else begin
          act_d = ACT_INS;
          ep_d  = count_r;
        end
      end
      OP_REM_AT: begin
        if (count_r == '0) begin
          status_d = ST_EMPTY;
        end else if (item_r.position >= count_r) begin
          status_d = ST_RANGE;
        end else begin
          act_d = ACT_REM;
          ep_d  = item_r.position;
        end
      end
      OP_POP_FRONT: begin
        if (count_r == '0) begin
          status_d = ST_EMPTY;
        end else begin
          act_d = ACT_REM;
        end
      end
      OP_POP_BACK: begin
        if (count_r == '0) begin
          status_d = ST_EMPTY;
        end else begin
          act_d = ACT_REM;
          ep_d  = count_r - 1'b1;
        end
      end
      OP_FIND: begin
        act_d = ACT_FIND;
      end
      default: begin
        act_d = ACT_NONE;
      end
    endcase
  end

  always_comb begin
    rem_d = '0;
    ptr_d = '0;
    case (act_d)
      ACT_INS: begin
        rem_d = count_r - ep_d;
        ptr_d = count_r - 1'b1;
      end
      ACT_REM: begin
        rem_d = count_r - 1'b1 - ep_d;
        ptr_d = ep_d + 1'b1;
      end
      ACT_FIND: begin
        rem_d = count_r;
      end
      default: begin
        rem_d = '0;
      end
    endcase
  end

  assign issue = cmd.step && (rem_r != '0);

  // moved entries are written in the cycle after their read
  always_comb begin
    we    = 1'b0;
    waddr = wa_r;
    wdata = rdata;
    if (cmd.step && pend_r && (act_r != ACT_FIND)) begin
      we = 1'b1;
    end else if (cmd.commit && (act_r == ACT_INS)) begin
      we    = 1'b1;
      waddr = ep_r;
      wdata = $unsigned(item_r.key);
    end
  end

  ilirs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt = count_r;
    case (act_r)
      ACT_INS:  count_nxt = count_r + 1'b1;
      ACT_REM:  count_nxt = count_r - 1'b1;
      default:  count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.start) begin
      act_r    <= act_d;
      status_r <= status_d;
      ep_r     <= ep_d[ADDR_W-1:0];
      rem_r    <= rem_d;
      ptr_r    <= ptr_d;
    end else if (issue) begin
      rem_r <= rem_r - 1'b1;
      if (act_r == ACT_INS) begin
        ptr_r <= ptr_r - 1'b1;
        wa_r  <= ptr_r[ADDR_W-1:0] + 1'b1;
      end else begin
        ptr_r <= ptr_r + 1'b1;
        wa_r  <= ptr_r[ADDR_W-1:0] - 1'b1;
      end
    end
    if (cmd.start) begin
      found_r <= 1'b0;
    end else if (cmd.step && pend_r && (act_r == ACT_FIND) && (rdata == item_r.key)) begin
      found_r <= 1'b1;
    end
    if (cmd.commit) begin
      out_r.status <= status_r;
      out_r.found  <= found_r;
      out_r.count  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
      pend_r <= issue;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.scan_done = (rem_r == '0) && !pend_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

@@ sv/ilirs_checker.sv @@
`timescale 1ns / 1ps
// port level checks for the indexed list, bound to the top level
// depends on ilirs_pkg
module ilirs_checker import ilirs_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.status == ST_OK)
    else $error("found flag with error status");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.count == CAP_CNT)
    else $error("full status on a list that is not full");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.count == '0)
    else $error("empty status on a list that is not empty");

endmodule

bind indexed_list_insert_remove_search ilirs_checker u_chk (.*);
